// ===== hdl/puc_pkg.sv =====
package puc_pkg;

   localparam int unsigned ValueW = 32;
   localparam int unsigned LevelW = 33;

   localparam logic signed [LevelW-1:0] LEVEL_ONE = 33'sh0_0100_0000;
   localparam logic signed [LevelW-1:0] LEVEL_MAX = 33'sh0_7FFF_FFFF;
   localparam logic signed [LevelW-1:0] LEVEL_MIN = -33'sh0_8000_0000;

   localparam logic [1:0] STATUS_FOUND      = 2'd0;
   localparam logic [1:0] STATUS_WRONG_SIDE = 2'd1;
   localparam logic [1:0] STATUS_NONE       = 2'd2;

   localparam logic CSR_DIFF_MODE    = 1'b0;
   localparam logic CSR_OVER_DENSITY = 1'b1;

   typedef enum logic [1:0] {
      KIND_DIRECT,
      KIND_HOLD,
      KIND_PAIR
   } kind_type;

   typedef struct packed {
      logic [ValueW-1:0] value;
      logic [ValueW-1:0] radius;
      logic              last;
      kind_type          kind;
   } item_type;

   typedef struct packed {
      logic [ValueW-1:0] radius;
      logic [1:0]        status;
   } result_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== hdl/puc_front.sv =====
module puc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [31:0]            value,
   input  logic [31:0]            radius,
   input  logic                   last,
   input  logic                   diff_mode,
   input  logic                   pop,
   output puc_pkg::q_status_type  q_status,
   output puc_pkg::item_type      head
);

   puc_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       held_ff, held_in;
   logic       do_push, do_pop;
   puc_pkg::item_type item;

   assign full = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop = pop && (count_ff != 2'd0);
   assign q_status.empty = (count_ff == 2'd0);
   assign q_status.full = full;
   assign head = mem_ff[rd_ptr_ff];

   // classify: a differential point with nothing held only primes the pair
   always_comb begin
      item.value = value;
      item.radius = radius;
      item.last = last;
      if (!diff_mode) begin
         item.kind = puc_pkg::KIND_DIRECT;
      end else if (held_ff) begin
         item.kind = puc_pkg::KIND_PAIR;
      end else begin
         item.kind = puc_pkg::KIND_HOLD;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      held_in = held_ff;
      if (do_push) begin
         wr_ptr_in = !wr_ptr_ff;
         held_in = !last;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
         held_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== hdl/puc_out_q.sv =====
module puc_out_q (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  puc_pkg::result_type   data,
   output logic                  full,
   output logic                  empty,
   input  logic                  pop,
   output puc_pkg::result_type   head
);

   puc_pkg::result_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data;
      end
   end

endmodule

// ===== hdl/puc_back.sv =====
module puc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  over_density,
   input  puc_pkg::q_status_type q_status,
   input  puc_pkg::item_type     head,
   output logic                  pop,
   input  logic                  oq_full,
   output logic                  oq_push,
   output puc_pkg::result_type   oq_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_SUBTR,
      S_DIV_CHK,
      S_DIV,
      S_CONTRAST,
      S_TAKE,
      S_INT_CHK,
      S_INT_DIV,
      S_INT_MUL,
      S_INT_END,
      S_AFTER,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   puc_pkg::item_type item_ff, item_in;

   // wide multiply, one limb a cycle
   logic [3:0][31:0] w_ff, w_in, w_new;
   logic [63:0]  mul_ff, mul_in, sum;
   logic [31:0]  mul_a, mul_b, mfac;
   logic [31:0]  carry_ff, carry_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [1:0]   mstep_ff, mstep_in;
   logic [1:0]   grp_ff, grp_in;
   logic [127:0] a_ff, a_in, b_ff, b_in, den_ff, den_in;
   logic [127:0] num_ff, num_in;
   logic [129:0] dv_ff, dv_in;
   logic         negn_ff, negn_in, neg_ff, neg_in;
   logic [31:0]  q_ff, q_in;
   logic [4:0]   bit_ff, bit_in;
   logic [31:0]  dr;

   // profile state
   logic [31:0]        held_v_ff, held_v_in, held_r_ff, held_r_in;
   logic signed [32:0] prev_ff, prev_in, level_ff, level_in;
   logic [31:0]        prev_rad_ff, prev_rad_in, lrad_ff, lrad_in;
   logic [1:0]         seen_ff, seen_in;
   logic               above_ff, above_in, done_ff, done_in, second_ff, second_in;
   logic [31:0]        ans_ff, ans_in;
   logic [1:0]         st_ff, st_in;

   // interpolation
   logic signed [34:0] n_s, d_s;
   logic [33:0]        an, ad;
   logic [34:0]        irem_ff, irem_in, rem2;
   logic [33:0]        iad_ff, iad_in;
   logic [31:0]        frac_ff, frac_in, adr_ff, adr_in, adr_c;
   logic               rdir_ff, rdir_in;
   logic               above_c, crossed;

   assign dr = (item_ff.radius >= held_r_ff) ? item_ff.radius - held_r_ff
                                             : held_r_ff - item_ff.radius;

   always_comb begin
      case (grp_ff)
         2'd0: mfac = item_ff.radius;
         2'd1: mfac = held_r_ff;
         default: mfac = (mstep_ff == 2'd2) ? dr : held_r_ff;
      endcase
   end

   assign mul_in = mul_a * mul_b;
   assign sum = mul_ff + {32'd0, carry_ff};

   always_comb begin
      w_new = w_ff;
      if (cnt_ff != 3'd0) begin
         w_new[2'(cnt_ff - 3'd1)] = sum[31:0];
      end
   end

   assign n_s = 35'(puc_pkg::LEVEL_ONE) - 35'(prev_ff);
   assign d_s = 35'(level_ff) - 35'(prev_ff);
   assign an = n_s[34] ? 34'(-n_s) : n_s[33:0];
   assign ad = d_s[34] ? 34'(-d_s) : d_s[33:0];
   assign adr_c = (lrad_ff >= prev_rad_ff) ? lrad_ff - prev_rad_ff : prev_rad_ff - lrad_ff;
   assign rem2 = {irem_ff[33:0], 1'b0};
   assign above_c = level_ff > puc_pkg::LEVEL_ONE;
   assign crossed = above_ff ? (level_ff <= puc_pkg::LEVEL_ONE)
                             : (level_ff >= puc_pkg::LEVEL_ONE);

   assign pop = (state_ff == S_IDLE) && !q_status.empty;
   assign oq_push = (state_ff == S_FINISH) && item_ff.last && !oq_full;
   assign oq_data.radius = (st_ff == puc_pkg::STATUS_FOUND) ? ans_ff : 32'd0;
   assign oq_data.status = st_ff;

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      w_in = w_ff;
      carry_in = carry_ff;
      cnt_in = cnt_ff;
      mstep_in = mstep_ff;
      grp_in = grp_ff;
      a_in = a_ff;
      b_in = b_ff;
      den_in = den_ff;
      num_in = num_ff;
      dv_in = dv_ff;
      negn_in = negn_ff;
      neg_in = neg_ff;
      q_in = q_ff;
      bit_in = bit_ff;
      held_v_in = held_v_ff;
      held_r_in = held_r_ff;
      prev_in = prev_ff;
      prev_rad_in = prev_rad_ff;
      level_in = level_ff;
      lrad_in = lrad_ff;
      seen_in = seen_ff;
      above_in = above_ff;
      done_in = done_ff;
      second_in = second_ff;
      ans_in = ans_ff;
      st_in = st_ff;
      irem_in = irem_ff;
      iad_in = iad_ff;
      frac_in = frac_ff;
      adr_in = adr_ff;
      rdir_in = rdir_ff;
      mul_a = w_ff[cnt_ff[1:0]];
      mul_b = mfac;

      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               item_in = head;
               case (head.kind)
                  puc_pkg::KIND_DIRECT: begin
                     level_in = {1'b0, head.value};
                     lrad_in = head.radius;
                     second_in = 1'b0;
                     state_in = S_TAKE;
                  end
                  puc_pkg::KIND_PAIR: begin
                     w_in = {96'd0, head.value};
                     grp_in = 2'd0;
                     mstep_in = 2'd0;
                     cnt_in = 3'd0;
                     carry_in = 32'd0;
                     state_in = S_MUL;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_MUL: begin
            if (cnt_ff != 3'd0) begin
               w_in = w_new;
               carry_in = sum[63:32];
            end
            if (cnt_ff == 3'd4) begin
               cnt_in = 3'd0;
               carry_in = 32'd0;
               if (mstep_ff == 2'd2) begin
                  mstep_in = 2'd0;
                  grp_in = grp_ff + 2'd1;
                  case (grp_ff)
                     2'd0: begin
                        a_in = w_new;
                        w_in = {96'd0, held_v_ff};
                     end
                     2'd1: begin
                        b_in = w_new;
                        w_in = 128'd3;
                     end
                     default: begin
                        den_in = w_new;
                        state_in = S_SUBTR;
                     end
                  endcase
               end else begin
                  mstep_in = mstep_ff + 2'd1;
               end
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_SUBTR: begin
            negn_in = a_ff < b_ff;
            num_in = (a_ff < b_ff) ? b_ff - a_ff : a_ff - b_ff;
            neg_in = (a_ff < b_ff) ^ (item_ff.radius < held_r_ff);
            state_in = S_DIV_CHK;
         end
         S_DIV_CHK: begin
            lrad_in = held_r_ff;
            second_in = item_ff.last;
            if (num_ff == 128'd0) begin
               level_in = '0;
               state_in = S_TAKE;
            end else if (den_ff == 128'd0) begin
               level_in = negn_ff ? puc_pkg::LEVEL_MIN : puc_pkg::LEVEL_MAX;
               state_in = S_TAKE;
            end else if ({2'b00, num_ff} >= {den_ff[97:0], 32'd0}) begin
               q_in = 32'hFFFF_FFFF;
               state_in = S_CONTRAST;
            end else begin
               dv_in = {1'b0, den_ff[97:0], 31'd0};
               q_in = 32'd0;
               bit_in = 5'd31;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if ({2'b00, num_ff} >= dv_ff) begin
               num_in = num_ff - dv_ff[127:0];
               q_in[bit_ff] = 1'b1;
            end
            dv_in = dv_ff >> 1;
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               state_in = S_CONTRAST;
            end
         end
         S_CONTRAST: begin
            if (neg_ff) begin
               level_in = q_ff[31] ? puc_pkg::LEVEL_MIN : -$signed({1'b0, q_ff});
            end else begin
               level_in = q_ff[31] ? puc_pkg::LEVEL_MAX : $signed({1'b0, q_ff});
            end
            lrad_in = held_r_ff;
            second_in = item_ff.last;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            state_in = S_AFTER;
            if (!done_ff) begin
               if (seen_ff == 2'd0) begin
                  above_in = above_c;
                  if (above_c != over_density) begin
                     done_in = 1'b1;
                     st_in = puc_pkg::STATUS_WRONG_SIDE;
                     ans_in = 32'd0;
                  end else begin
                     prev_in = level_ff;
                     prev_rad_in = lrad_ff;
                     seen_in = 2'd1;
                  end
               end else if (crossed) begin
                  state_in = S_INT_CHK;
               end else begin
                  prev_in = level_ff;
                  prev_rad_in = lrad_ff;
                  if (seen_ff != 2'd2) begin
                     seen_in = seen_ff + 2'd1;
                  end
               end
            end
         end
         S_INT_CHK: begin
            done_in = 1'b1;
            st_in = puc_pkg::STATUS_FOUND;
            adr_in = adr_c;
            rdir_in = lrad_ff >= prev_rad_ff;
            if (ad == 34'd0) begin
               ans_in = prev_rad_ff;
               state_in = S_AFTER;
            end else if (an >= ad) begin
               ans_in = lrad_ff;
               state_in = S_AFTER;
            end else begin
               irem_in = {1'b0, an};
               iad_in = ad;
               frac_in = 32'd0;
               bit_in = 5'd31;
               state_in = S_INT_DIV;
            end
         end
         S_INT_DIV: begin
            if (rem2 >= {1'b0, iad_ff}) begin
               irem_in = rem2 - {1'b0, iad_ff};
               frac_in = {frac_ff[30:0], 1'b1};
            end else begin
               irem_in = rem2;
               frac_in = {frac_ff[30:0], 1'b0};
            end
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               state_in = S_INT_MUL;
            end
         end
         S_INT_MUL: begin
            mul_a = frac_ff;
            mul_b = adr_ff;
            state_in = S_INT_END;
         end
         S_INT_END: begin
            ans_in = rdir_ff ? prev_rad_ff + mul_ff[63:32] : prev_rad_ff - mul_ff[63:32];
            state_in = S_AFTER;
         end
         S_AFTER: begin
            if (second_ff) begin
               second_in = 1'b0;
               lrad_in = item_ff.radius;
               state_in = S_TAKE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            held_v_in = item_ff.value;
            held_r_in = item_ff.radius;
            if (!item_ff.last) begin
               state_in = S_IDLE;
            end else if (!oq_full) begin
               held_v_in = 32'd0;
               held_r_in = 32'd0;
               prev_in = '0;
               prev_rad_in = 32'd0;
               seen_in = 2'd0;
               above_in = 1'b0;
               done_in = 1'b0;
               ans_in = 32'd0;
               st_in = puc_pkg::STATUS_NONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_v_ff <= 32'd0;
         held_r_ff <= 32'd0;
         prev_ff <= '0;
         prev_rad_ff <= 32'd0;
         seen_ff <= 2'd0;
         above_ff <= 1'b0;
         done_ff <= 1'b0;
         second_ff <= 1'b0;
         ans_ff <= 32'd0;
         st_ff <= puc_pkg::STATUS_NONE;
         cnt_ff <= 3'd0;
         mstep_ff <= 2'd0;
         grp_ff <= 2'd0;
         bit_ff <= 5'd0;
      end else begin
         state_ff <= state_in;
         held_v_ff <= held_v_in;
         held_r_ff <= held_r_in;
         prev_ff <= prev_in;
         prev_rad_ff <= prev_rad_in;
         seen_ff <= seen_in;
         above_ff <= above_in;
         done_ff <= done_in;
         second_ff <= second_in;
         ans_ff <= ans_in;
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         mstep_ff <= mstep_in;
         grp_ff <= grp_in;
         bit_ff <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      w_ff <= w_in;
      mul_ff <= mul_in;
      carry_ff <= carry_in;
      a_ff <= a_in;
      b_ff <= b_in;
      den_ff <= den_in;
      num_ff <= num_in;
      dv_ff <= dv_in;
      negn_ff <= negn_in;
      neg_ff <= neg_in;
      q_ff <= q_in;
      level_ff <= level_in;
      lrad_ff <= lrad_in;
      irem_ff <= irem_in;
      iad_ff <= iad_in;
      frac_ff <= frac_in;
      adr_ff <= adr_in;
      rdir_ff <= rdir_in;
   end

endmodule

// ===== hdl/profile_unity_crossing_radius.sv =====
// Finds where a radial profile crosses 1.0. Points (value Q8.24, radius Q0.32) are pushed
// in order, the last one flagged; one result (radius, status) is queued per profile on its
// last point. A two-entry input queue takes points while the back end works. A direct point
// needs no arithmetic; a differential pair runs the single 32x32 multiplier through nine wide
// products limb by limb and then, unless the quotient is zero or saturates, the 32-step
// contrast divider; the point that holds the first point of a differential profile needs no
// arithmetic. The point at which a crossing is found adds interpolation (32-step fraction
// divider and one multiply). The last point of a differential profile adds its second level.
// A full result queue holds the back end on the last point until space frees.
module profile_unity_crossing_radius (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_profile_value,
   input  logic [31:0] req_radius,
   input  logic        req_last_point,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_crossing_radius,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data
);

   logic diff_mode_ff, over_density_ff;
   logic pop, oq_full, oq_push;
   puc_pkg::q_status_type q_status;
   puc_pkg::item_type     head;
   puc_pkg::result_type   oq_data, rsp_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_mode_ff <= 1'b0;
         over_density_ff <= 1'b0;
      end else if (csr_write_enable) begin
         if (csr_index == puc_pkg::CSR_DIFF_MODE) begin
            diff_mode_ff <= csr_write_data;
         end
         if (csr_index == puc_pkg::CSR_OVER_DENSITY) begin
            over_density_ff <= csr_write_data;
         end
      end
   end

   puc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .value     (req_profile_value),
      .radius    (req_radius),
      .last      (req_last_point),
      .diff_mode (diff_mode_ff),
      .pop       (pop),
      .q_status  (q_status),
      .head      (head)
   );

   puc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .over_density (over_density_ff),
      .q_status     (q_status),
      .head         (head),
      .pop          (pop),
      .oq_full      (oq_full),
      .oq_push      (oq_push),
      .oq_data      (oq_data)
   );

   puc_out_q u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (oq_push),
      .data  (oq_data),
      .full  (oq_full),
      .empty (rsp_empty),
      .pop   (rsp_pop),
      .head  (rsp_head)
   );

   assign rsp_crossing_radius = rsp_head.radius;
   assign rsp_status = rsp_head.status;

endmodule
